FILE: rtl/pgtd_pkg.sv
// Shared types and constants for the pixel gray/threshold/downscale block.
// Depends on nothing; imported by the register file and the top level.
`timescale 1ns / 1ps

package pgtd_pkg;

    localparam int CH_W   = 8;   // one color channel
    localparam int PAIR_W = 9;   // sum of two channels
    localparam int LINE_W = 3 * PAIR_W;
    localparam int SUM3_W = 10;  // sum of three channels
    localparam int MODE_W = 2;
    localparam int SIZE_W = 13;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register index codes, taken from paddr[3:2]
    localparam logic [1:0] REG_FILTER_MODE  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_THRESHOLD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GRAY      = 2'd1;

    // divide by three as multiply by 683 / 2048, exact for sums up to 765
    localparam logic [SUM3_W:0] RECIP_3     = 11'd683;
    localparam int              RECIP_SHIFT = 11;

    localparam logic [CH_W-1:0] THRESH_LEVEL = 8'd128;
    localparam logic [CH_W-1:0] PIX_WHITE    = 8'hff;
    localparam logic [CH_W-1:0] PIX_BLACK    = 8'h00;

    typedef struct packed {
        logic [MODE_W-1:0] filter_mode;
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
        logic              restart;
    } cfg_t;

endpackage

FILE: rtl/pgtd_cfg_regs.sv
// APB register file: filter mode, image width and image height.
// Depends on pgtd_pkg; flags a frame restart on every valid register write.
`timescale 1ns / 1ps

module pgtd_cfg_regs
    import pgtd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [MODE_W-1:0] mode_reg,   mode_next;
    logic [SIZE_W-1:0] width_reg,  width_next;
    logic [SIZE_W-1:0] height_reg, height_next;
    logic              wr_en;
    logic              wr_hit;
    logic [1:0]        reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_comb
    begin
        mode_next   = mode_reg;
        width_next  = width_reg;
        height_next = height_reg;
        wr_hit      = 1'b0;
        if (wr_en)
        begin
            case (reg_index)
                REG_FILTER_MODE:
                begin
                    mode_next = pwdata[MODE_W-1:0];
                    wr_hit    = 1'b1;
                end
                REG_IMAGE_WIDTH:
                begin
                    width_next = pwdata[SIZE_W-1:0];
                    wr_hit     = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = pwdata[SIZE_W-1:0];
                    wr_hit      = 1'b1;
                end
                default:
                begin
                    wr_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_THRESHOLD;
            width_reg  <= SIZE_W'(1);
            height_reg <= SIZE_W'(1);
        end
        else
        begin
            mode_reg   <= mode_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_FILTER_MODE:  prdata = DATA_W'(mode_reg);
            REG_IMAGE_WIDTH:  prdata = DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.filter_mode  = mode_reg;
    assign cfg.image_width  = width_reg;
    assign cfg.image_height = height_reg;
    assign cfg.restart      = wr_hit;

endmodule

FILE: rtl/pixel_gray_threshold_downscale.sv
// Top level of the pixel gray/threshold/downscale block.
// Depends on pgtd_pkg and pgtd_cfg_regs; holds the line store of pair sums.
`timescale 1ns / 1ps

// Takes one pixel word per clock in raster order and keeps that rate in every
// mode: a new pixel is accepted each cycle unless the stage behind the result
// register is full while the receiver stalls a waiting result. A pixel goes
// into that stage, beside the registered read of the single line store that
// holds the horizontal pair sums of the last even row (at most one read or one
// write per accepted pixel, never both on the same entry in one cycle), then
// into the output register. In threshold and grayscale mode each pixel gives
// one result; in downscale mode one result comes per 2x2 block, on the odd pixel
// of each odd row, and an odd last row or column is dropped. frame_last marks
// the final result of a frame. Any register write restarts the frame and must
// happen while the block is idle. The line store is not cleared after reset;
// no entry is read before the row above has written it.
module pixel_gray_threshold_downscale
    import pgtd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  logic [CH_W-1:0]   blue,
    input  logic [CH_W-1:0]   green,
    input  logic [CH_W-1:0]   red,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [CH_W-1:0]   out_blue,
    output logic [CH_W-1:0]   out_green,
    output logic [CH_W-1:0]   out_red,
    output logic              frame_last
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int LA_W       = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WB         = $clog2(MAX_WIDTH + 1);
    localparam int HB         = $clog2(MAX_HEIGHT + 1);
    localparam int CWW        = (WB > SIZE_W) ? WB : SIZE_W;
    localparam int CHW        = (HB > SIZE_W) ? HB : SIZE_W;

    cfg_t cfg;

    pgtd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // clamp the frame size to 1..MAX
    logic [CWW-1:0] width_ext;
    logic [CHW-1:0] height_ext;
    logic [WB-1:0]  w_size;
    logic [HB-1:0]  h_size;
    logic [WB-1:0]  w_last;
    logic [HB-1:0]  h_last;
    logic [WB-1:0]  w_even_last;
    logic [HB-1:0]  h_even_last;

    always_comb
    begin
        width_ext  = CWW'(cfg.image_width);
        height_ext = CHW'(cfg.image_height);
        if (width_ext == '0)
            w_size = WB'(1);
        else if (width_ext > CWW'(MAX_WIDTH))
            w_size = WB'(MAX_WIDTH);
        else
            w_size = WB'(width_ext);
        if (height_ext == '0)
            h_size = HB'(1);
        else if (height_ext > CHW'(MAX_HEIGHT))
            h_size = HB'(MAX_HEIGHT);
        else
            h_size = HB'(height_ext);
        w_last      = w_size - WB'(1);
        h_last      = h_size - HB'(1);
        w_even_last = {w_size[WB-1:1], 1'b0} - WB'(1);
        h_even_last = {h_size[HB-1:1], 1'b0} - HB'(1);
    end

    // position and pair hold
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [LINE_W-1:0] pair_hold_reg, pair_hold_next;

    logic              accept;
    logic              ds_mode;
    logic              odd_col;
    logic              odd_row;
    logic              col_end;
    logic              row_end;
    logic              produces;
    logic              line_wr;
    logic              line_rd;
    logic [LA_W-1:0]   line_addr;
    logic [LINE_W-1:0] pair_sum;
    logic [SUM3_W-1:0] sum3;
    logic [SUM3_W+SUM3_W:0] sum3_prod;
    logic [CH_W-1:0]   avg;
    logic [CH_W-1:0]   direct_value;
    logic              last_flag;

    assign accept    = pixel_valid && !pixel_stall;
    assign ds_mode   = cfg.filter_mode[1];
    assign odd_col   = col_reg[0];
    assign odd_row   = row_reg[0];
    assign col_end   = (WB'(col_reg) == w_last);
    assign row_end   = (HB'(row_reg) == h_last);
    assign produces  = !ds_mode || (odd_col && odd_row);
    assign line_wr   = accept && ds_mode && odd_col && !odd_row;
    assign line_rd   = accept && ds_mode && odd_col && odd_row;
    assign line_addr = LA_W'(col_reg >> 1);

    assign pair_sum = {
        PAIR_W'(pair_hold_reg[3*PAIR_W-1:2*PAIR_W]) + PAIR_W'(red),
        PAIR_W'(pair_hold_reg[2*PAIR_W-1:PAIR_W])   + PAIR_W'(green),
        PAIR_W'(pair_hold_reg[PAIR_W-1:0])          + PAIR_W'(blue)
    };

    always_comb
    begin
        sum3      = SUM3_W'(blue) + SUM3_W'(green) + SUM3_W'(red);
        sum3_prod = (SUM3_W+SUM3_W+1)'(sum3) * (SUM3_W+SUM3_W+1)'(RECIP_3);
        avg       = sum3_prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
        if (cfg.filter_mode == MODE_GRAY)
            direct_value = avg;
        else
            direct_value = (avg >= THRESH_LEVEL) ? PIX_WHITE : PIX_BLACK;
        if (ds_mode)
            last_flag = (HB'(row_reg) == h_even_last) && (WB'(col_reg) == w_even_last);
        else
            last_flag = row_end && col_end;
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        pair_hold_next = pair_hold_reg;
        if (cfg.restart)
        begin
            col_next       = '0;
            row_next       = '0;
            pair_hold_next = '0;
        end
        else if (accept)
        begin
            if (ds_mode && !odd_col)
                pair_hold_next = {PAIR_W'(red), PAIR_W'(green), PAIR_W'(blue)};
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // line store of pair sums, registered read
    logic [LINE_W-1:0] line_mem [LINE_DEPTH];
    logic [LINE_W-1:0] line_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (line_wr)
            line_mem[line_addr] <= pair_sum;
        if (line_rd)
            line_rdata_reg <= line_mem[line_addr];
    end

    // stage behind the line store read, then the result register
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_ds_reg;
    logic [CH_W-1:0]   s1_value_reg;
    logic [LINE_W-1:0] s1_sum_reg;
    logic              s1_last_reg;
    logic              out_load;
    logic              s1_move;
    logic              result_valid_reg, result_valid_next;
    logic [CH_W-1:0]   out_blue_reg, out_green_reg, out_red_reg;
    logic              frame_last_reg;
    logic [PAIR_W:0]   box_b, box_g, box_r;

    assign out_load    = !result_valid_reg || !result_stall;
    assign s1_move     = s1_valid_reg && out_load;
    assign pixel_stall = s1_valid_reg && !out_load;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = produces;
        else if (s1_move)
            s1_valid_next = 1'b0;
        result_valid_next = result_valid_reg;
        if (out_load)
            result_valid_next = s1_valid_reg;
        box_b = (PAIR_W+1)'(line_rdata_reg[PAIR_W-1:0])
              + (PAIR_W+1)'(s1_sum_reg[PAIR_W-1:0]);
        box_g = (PAIR_W+1)'(line_rdata_reg[2*PAIR_W-1:PAIR_W])
              + (PAIR_W+1)'(s1_sum_reg[2*PAIR_W-1:PAIR_W]);
        box_r = (PAIR_W+1)'(line_rdata_reg[3*PAIR_W-1:2*PAIR_W])
              + (PAIR_W+1)'(s1_sum_reg[3*PAIR_W-1:2*PAIR_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            pair_hold_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg          <= col_next;
            row_reg          <= row_next;
            pair_hold_reg    <= pair_hold_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ds_reg    <= ds_mode;
            s1_value_reg <= direct_value;
            s1_sum_reg   <= pair_sum;
            s1_last_reg  <= last_flag;
        end
        if (s1_move)
        begin
            frame_last_reg <= s1_last_reg;
            if (s1_ds_reg)
            begin
                out_blue_reg  <= box_b[PAIR_W:2];
                out_green_reg <= box_g[PAIR_W:2];
                out_red_reg   <= box_r[PAIR_W:2];
            end
            else
            begin
                out_blue_reg  <= s1_value_reg;
                out_green_reg <= s1_value_reg;
                out_red_reg   <= s1_value_reg;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign out_blue     = out_blue_reg;
    assign out_green    = out_green_reg;
    assign out_red      = out_red_reg;
    assign frame_last   = frame_last_reg;

endmodule
